/* rtl/core/boid_pkg.sv */
// Shared types and constants for the BER object identifier to text unit.
// No dependencies; imported by every module in rtl/core.
`default_nettype none
package boid_pkg;

    localparam int ARC_WIDTH_DEF = 64;  // default accumulator width
    localparam int FIFO_DEPTH    = 2;   // front-to-back job queue
    localparam int DD_BITS       = 4;   // double-dabble bits per cycle

    localparam logic [7:0] FIRST_SPLIT = 8'd40;
    localparam logic [7:0] THIRD_BASE  = 8'd80;
    localparam logic [6:0] GROUP_MASK  = 7'h7f;
    localparam int         CONT_BIT    = 7;

    localparam logic [7:0] ASCII_DOT  = 8'h2e;
    localparam logic [7:0] ASCII_ZERO = 8'h30;

    // leading arc of the first sub-identifier, if the job carries one
    localparam logic [1:0] LEAD_NONE = 2'd0;
    localparam logic [1:0] LEAD_0    = 2'd1;
    localparam logic [1:0] LEAD_1    = 2'd2;
    localparam logic [1:0] LEAD_2    = 2'd3;

    typedef struct packed {
        logic [1:0] lead;
        logic       ovf;
        logic       fin;
    } t_job_ctl;

    localparam int JOB_CTL_W = $bits(t_job_ctl);

endpackage
`default_nettype wire

/* rtl/core/ber_oid_to_dotted_decimal_unit.sv */
// BER OID content bytes in, dotted-decimal ASCII out. A completing byte's job is registered
// into the job queue, converted to BCD by double dabble, and its first char then registered.
// Continuation bytes are taken while the job queue is not full; the front end keeps taking
// bytes while the back end converts and emits an earlier arc, a leading arc adding one char.
// Reset (sync, active low): first arc expected, accumulator clear, queue and output empty.
// Depends on boid_pkg, boid_front, boid_fifo, boid_back.
`default_nettype none
module ber_oid_to_dotted_decimal_unit
    import boid_pkg::*;
#(
    parameter int ARC_WIDTH = ARC_WIDTH_DEF   // 32..64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // byte word in
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_oid_byte,
    input  wire logic       i_final_byte,
    // character word out
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_text_char,
    output logic            o_run_last,
    output logic            o_string_end,
    output logic            o_arc_overflow
);

    localparam int JOB_W = ARC_WIDTH + JOB_CTL_W;

    logic                 accept;
    logic                 push;
    logic [ARC_WIDTH-1:0] push_value;
    t_job_ctl             push_ctl;
    logic [JOB_W-1:0]     q_out;
    logic                 q_full, q_empty, pop;
    logic [ARC_WIDTH-1:0] job_value;
    t_job_ctl             job_ctl;

    // front stalls only when the job queue is full
    assign o_stall = q_full;
    assign accept  = i_valid && !q_full;

    boid_front #(
        .ARC_WIDTH (ARC_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_oid_byte   (i_oid_byte),
        .i_final_byte (i_final_byte),
        .o_push       (push),
        .o_value      (push_value),
        .o_ctl        (push_ctl)
    );

    boid_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_value, push_ctl}),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign job_value = q_out[JOB_W-1:JOB_CTL_W];
    assign job_ctl   = q_out[JOB_CTL_W-1:0];

    boid_back #(
        .ARC_WIDTH (ARC_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_avail    (!q_empty),
        .i_value        (job_value),
        .i_ctl          (job_ctl),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_text_char    (o_text_char),
        .o_run_last     (o_run_last),
        .o_string_end   (o_string_end),
        .o_arc_overflow (o_arc_overflow)
    );

endmodule
`default_nettype wire

/* rtl/core/boid_front.sv */
// Front end: takes OID content bytes, gathers base-128 groups, issues arc jobs.
// Depends on boid_pkg.
`default_nettype none
module boid_front
    import boid_pkg::*;
#(
    parameter int ARC_WIDTH = ARC_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [7:0]           i_oid_byte,
    input  wire logic                 i_final_byte,
    output logic                      o_push,
    output logic [ARC_WIDTH-1:0]      o_value,
    output t_job_ctl                  o_ctl
);

    logic [ARC_WIDTH-1:0] r_acc, n_acc;
    logic                 r_first, n_first;
    logic                 r_open, n_open;
    logic                 r_ovf, n_ovf;

    logic [ARC_WIDTH-1:0] acc_grow;
    logic                 ovf_grow;
    logic [7:0]           small_v;
    logic                 short_first;
    logic                 done;

    always_comb begin
        short_first = r_first && !r_open && (i_oid_byte < THIRD_BASE);
        small_v     = (i_oid_byte < FIRST_SPLIT) ? i_oid_byte : i_oid_byte - FIRST_SPLIT;
        if (r_open) begin
            acc_grow = {r_acc[ARC_WIDTH-8:0], i_oid_byte[6:0] & GROUP_MASK};
            ovf_grow = r_ovf || (r_acc[ARC_WIDTH-1:ARC_WIDTH-7] != 7'd0);
        end else begin
            acc_grow = ARC_WIDTH'(i_oid_byte[6:0] & GROUP_MASK);
            ovf_grow = 1'b0;
        end
        done = !i_oid_byte[CONT_BIT] || i_final_byte;

        n_acc   = r_acc;
        n_first = r_first;
        n_open  = r_open;
        n_ovf   = r_ovf;
        o_push  = 1'b0;
        o_value = acc_grow;
        o_ctl.lead = LEAD_NONE;
        o_ctl.ovf  = ovf_grow;
        o_ctl.fin  = i_final_byte;

        if (i_accept) begin
            if (short_first) begin
                o_push     = 1'b1;
                o_value    = ARC_WIDTH'(small_v);
                o_ctl.lead = (i_oid_byte < FIRST_SPLIT) ? LEAD_0 : LEAD_1;
                o_ctl.ovf  = 1'b0;
                n_first    = 1'b0;
            end else if (done) begin
                o_push = 1'b1;
                if (r_first) begin
                    o_ctl.lead = LEAD_2;
                    o_value    = acc_grow - ARC_WIDTH'(THIRD_BASE);   // wraps
                end
                n_first = 1'b0;
                n_open  = 1'b0;
                n_acc   = '0;
                n_ovf   = 1'b0;
            end else begin
                n_acc  = acc_grow;
                n_ovf  = ovf_grow;
                n_open = 1'b1;
            end
            if (i_final_byte) begin
                n_acc   = '0;
                n_first = 1'b1;
                n_open  = 1'b0;
                n_ovf   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_first <= 1'b1;
            r_open  <= 1'b0;
            r_ovf   <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_first <= n_first;
            r_open  <= n_open;
            r_ovf   <= n_ovf;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/boid_fifo.sv */
// Small register queue carrying arc jobs from the front end to the back end.
// Depends on boid_pkg.
`default_nettype none
module boid_fifo
    import boid_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = FIFO_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/boid_back.sv */
// Back end: binary-to-BCD conversion of one arc and character output register.
// Depends on boid_pkg.
`default_nettype none
module boid_back
    import boid_pkg::*;
#(
    parameter int ARC_WIDTH = ARC_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_job_avail,
    input  wire logic [ARC_WIDTH-1:0] i_value,
    input  wire t_job_ctl             i_ctl,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [7:0]                o_text_char,
    output logic                      o_run_last,
    output logic                      o_string_end,
    output logic                      o_arc_overflow
);

    localparam int NDIG   = (ARC_WIDTH * 30103) / 100000 + 1;  // digits of 2^W-1
    localparam int BCD_W  = 4 * NDIG;
    localparam int NSTEP  = (ARC_WIDTH + DD_BITS - 1) / DD_BITS;
    localparam int PAD_W  = NSTEP * DD_BITS;
    localparam int CNT_W  = $clog2(NSTEP);
    localparam int DIG_IW = $clog2(NDIG);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CONV = 3'd1;
    localparam logic [2:0] S_LEAD = 3'd2;
    localparam logic [2:0] S_DOT  = 3'd3;
    localparam logic [2:0] S_DIG  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [PAD_W-1:0]  r_val, n_val;
    logic [BCD_W-1:0]  r_bcd, n_bcd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [DIG_IW-1:0] r_idx, n_idx;
    t_job_ctl          r_ctl, n_ctl;

    logic              r_ov, n_ov;
    logic [7:0]        r_char, n_char;
    logic              r_last, n_last;
    logic              r_end, n_end;
    logic              r_aovf, n_aovf;

    logic              slot_free;
    logic [PAD_W-1:0]  dd_val;
    logic [BCD_W-1:0]  dd_bcd;
    logic [DIG_IW-1:0] msd;
    logic [3:0]        cur_dig;
    logic              dd_in;

    assign slot_free = !r_ov || !i_stall;
    assign cur_dig   = r_bcd[4 * r_idx +: 4];

    // double dabble, DD_BITS bits a cycle
    always_comb begin
        dd_val = r_val;
        dd_bcd = r_bcd;
        dd_in  = 1'b0;
        for (int s = 0; s < DD_BITS; s++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (dd_bcd[4 * d +: 4] >= 4'd5) begin
                    dd_bcd[4 * d +: 4] = dd_bcd[4 * d +: 4] + 4'd3;
                end
            end
            dd_in  = dd_val[PAD_W-1];
            dd_val = {dd_val[PAD_W-2:0], 1'b0};
            dd_bcd = {dd_bcd[BCD_W-2:0], dd_in};
        end
    end

    // most significant nonzero digit; zero gives one digit
    always_comb begin
        msd = '0;
        for (int i = 0; i < NDIG; i++) begin
            if (r_bcd[4 * i +: 4] != 4'd0) begin
                msd = DIG_IW'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_val   = r_val;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_ctl   = r_ctl;
        o_pop   = 1'b0;

        n_ov   = r_ov && i_stall;
        n_char = r_char;
        n_last = r_last;
        n_end  = r_end;
        n_aovf = r_aovf;

        case (r_state)
            S_IDLE: begin
                if (i_job_avail) begin
                    o_pop   = 1'b1;
                    n_val   = PAD_W'(i_value);
                    n_bcd   = '0;
                    n_cnt   = CNT_W'(NSTEP - 1);
                    n_ctl   = i_ctl;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_val = dd_val;
                n_bcd = dd_bcd;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = (r_ctl.lead == LEAD_NONE) ? S_DOT : S_LEAD;
                end
            end
            S_LEAD: begin
                if (slot_free) begin
                    n_ov   = 1'b1;
                    n_last = 1'b0;
                    n_end  = 1'b0;
                    n_aovf = r_ctl.ovf;
                    case (r_ctl.lead)
                        LEAD_0:  n_char = ASCII_ZERO;
                        LEAD_1:  n_char = ASCII_ZERO + 8'd1;
                        default: n_char = ASCII_ZERO + 8'd2;
                    endcase
                    n_state = S_DOT;
                end
            end
            S_DOT: begin
                if (slot_free) begin
                    n_ov    = 1'b1;
                    n_char  = ASCII_DOT;
                    n_last  = 1'b0;
                    n_end   = 1'b0;
                    n_aovf  = r_ctl.ovf;
                    n_idx   = msd;
                    n_state = S_DIG;
                end
            end
            S_DIG: begin
                if (slot_free) begin
                    n_ov   = 1'b1;
                    n_char = ASCII_ZERO + {4'd0, cur_dig};
                    n_last = (r_idx == '0);
                    n_end  = (r_idx == '0) && r_ctl.fin;
                    n_aovf = r_ctl.ovf;
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_bcd  <= n_bcd;
        r_cnt  <= n_cnt;
        r_idx  <= n_idx;
        r_ctl  <= n_ctl;
        r_char <= n_char;
        r_last <= n_last;
        r_end  <= n_end;
        r_aovf <= n_aovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    assign o_valid        = r_ov;
    assign o_text_char    = r_char;
    assign o_run_last     = r_last;
    assign o_string_end   = r_end;
    assign o_arc_overflow = r_aovf;

endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
// Self-checking bench for ber_oid_to_dotted_decimal_unit: OID content bytes in,
// dotted-decimal ASCII words out, compared with a behavioural decoder held here.
// Depends on boid_pkg and the unit's RTL only.
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import boid_pkg::*;

    localparam int          ARC_W       = ARC_WIDTH_DEF;
    localparam logic [63:0] ARC_MASK    = {64{1'b1}} >> (64 - ARC_W);
    localparam int          CYCLE_LIMIT = 500000;
    localparam int          DRAIN_LIMIT = 20000;
    localparam int          SETTLE      = 64;

    // one expected output word
    typedef struct packed {
        logic [7:0] text_char;
        logic       run_last;
        logic       string_end;
        logic       arc_overflow;
    } t_text_word;

    // receiver back-pressure styles
    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_style;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_oid_byte;
    logic       i_final_byte;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_text_char;
    logic       o_run_last;
    logic       o_string_end;
    logic       o_arc_overflow;

    ber_oid_to_dotted_decimal_unit #(.ARC_WIDTH(ARC_W)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_oid_byte     (i_oid_byte),
        .i_final_byte   (i_final_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_text_char    (o_text_char),
        .o_run_last     (o_run_last),
        .o_string_end   (o_string_end),
        .o_arc_overflow (o_arc_overflow)
    );

    // decoder state, mirrors the unit between identifiers
    logic [63:0] arc_value;
    logic        first_arc_due;
    logic        arc_lost_bits;
    logic        arc_in_progress;

    t_text_word  text_due[$];     // characters still owed by the unit
    int          fail_count;
    int          cycle_count;
    int          bytes_sent;
    int          burst_left;
    bit          quiet;           // no idling on either side
    t_rx_style   rx_style;
    int          rx_phase_left;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Decode one accepted byte and queue the characters it must produce.
    task automatic decode_oid_byte(input logic [7:0] b, input logic fin);
        logic [7:0]  chars [0:21];
        logic [3:0]  digs  [0:19];
        logic [63:0] v;
        logic        ovf;
        logic        emit;
        int          n;
        int          nd;
        t_text_word  w;
        n    = 0;
        v    = '0;
        ovf  = 1'b0;
        emit = 1'b0;
        if (first_arc_due && !arc_in_progress && b < THIRD_BASE) begin
            // single-byte first sub-identifier splits as 0.x or 1.x
            chars[0] = (b < FIRST_SPLIT) ? ASCII_ZERO : ASCII_ZERO + 8'd1;
            chars[1] = ASCII_DOT;
            n = 2;
            v = (b < FIRST_SPLIT) ? {56'd0, b} : {56'd0, b} - {56'd0, FIRST_SPLIT};
            emit = 1'b1;
            first_arc_due = 1'b0;
        end else begin
            if (arc_in_progress) begin
                if ((arc_value >> (ARC_W - 7)) != 64'd0)
                    arc_lost_bits = 1'b1;
                arc_value = ((arc_value << 7) | {57'd0, b[6:0] & GROUP_MASK}) & ARC_MASK;
            end else begin
                arc_value     = {57'd0, b[6:0] & GROUP_MASK};
                arc_lost_bits = 1'b0;
            end
            arc_in_progress = 1'b1;
            // final byte flushes even with its continuation bit set
            if (!b[CONT_BIT] || fin) begin
                ovf  = arc_lost_bits;
                emit = 1'b1;
                if (first_arc_due) begin
                    chars[0] = ASCII_ZERO + 8'd2;
                    chars[1] = ASCII_DOT;
                    n = 2;
                    v = (arc_value - {56'd0, THIRD_BASE}) & ARC_MASK;   // wraps
                    first_arc_due = 1'b0;
                end else begin
                    chars[0] = ASCII_DOT;
                    n = 1;
                    v = arc_value;
                end
                arc_in_progress = 1'b0;
                arc_value       = '0;
                arc_lost_bits   = 1'b0;
            end
        end
        if (emit) begin
            nd = 0;
            do begin
                digs[nd] = 4'(v % 64'd10);
                v = v / 64'd10;
                nd++;
            end while (v != 64'd0 && nd < 20);
            while (nd > 0) begin
                nd--;
                chars[n] = ASCII_ZERO + {4'd0, digs[nd]};
                n++;
            end
        end
        for (int i = 0; i < n; i++) begin
            w.text_char    = chars[i];
            w.run_last     = (i == n - 1);
            w.string_end   = (i == n - 1) && fin;
            w.arc_overflow = ovf;
            text_due.push_back(w);
        end
        if (fin) begin
            arc_value       = '0;
            first_arc_due   = 1'b1;
            arc_lost_bits   = 1'b0;
            arc_in_progress = 1'b0;
        end
    endtask

    // Present one byte word and hold it until the unit takes it.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_oid_byte   <= b;
        i_final_byte <= fin;
        forever begin
            @(posedge i_clk);
            if (!o_stall)
                break;
        end
        decode_oid_byte(b, fin);
        bytes_sent++;
    endtask

    // Bursts of random length separated by random gaps.
    task automatic pace_sender;
        int gap;
        if (quiet)
            return;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(1, 12);
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    task automatic send_paced(input logic [7:0] b, input logic fin);
        send_byte(b, fin);
        pace_sender();
    endtask

    task automatic send_sequence(input logic [7:0] seq [$]);
        for (int i = 0; i < seq.size(); i++)
            send_paced(seq[i], i == seq.size() - 1);
    endtask

    task automatic stop_sending;
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained;
        int waited;
        waited = 0;
        while (text_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    // Receiver: compare each taken word with the oldest one owed.
    always @(posedge i_clk) begin
        t_text_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (text_due.size() == 0) begin
                $error("unexpected word: text_char %h", o_text_char);
                fail_count++;
            end else begin
                want = text_due.pop_front();
                if (o_text_char !== want.text_char) begin
                    $error("text_char: expected %h, got %h", want.text_char, o_text_char);
                    fail_count++;
                end
                if (o_run_last !== want.run_last) begin
                    $error("run_last: expected %b, got %b", want.run_last, o_run_last);
                    fail_count++;
                end
                if (o_string_end !== want.string_end) begin
                    $error("string_end: expected %b, got %b", want.string_end, o_string_end);
                    fail_count++;
                end
                if (o_arc_overflow !== want.arc_overflow) begin
                    $error("arc_overflow: expected %b, got %b",
                           want.arc_overflow, o_arc_overflow);
                    fail_count++;
                end
            end
        end
    end

    // Receiver stall pattern, switching style every so often.
    always @(negedge i_clk) begin
        if (rx_phase_left == 0) begin
            rx_style      <= t_rx_style'($urandom_range(0, 3));
            rx_phase_left <= $urandom_range(16, 200);
        end else begin
            rx_phase_left <= rx_phase_left - 1;
        end
        if (quiet || !i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            case (rx_style)
                RX_FREE:     i_stall <= 1'b0;
                RX_LIGHT:    i_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY:    i_stall <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: i_stall <= ((cycle_count % 5) < 2);
                default:     i_stall <= 1'b0;
            endcase
        end
    end

    // 0.x, 1.x and 2.x split of a single-byte first sub-identifier
    task automatic test_first_arc_split;
        send_paced(8'd0, 1'b1);
        send_paced(8'd39, 1'b1);
        send_paced(8'd40, 1'b1);
        send_paced(8'd79, 1'b1);
        send_paced(8'd80, 1'b1);
    endtask

    // final byte carrying the continuation bit still flushes its arc
    task automatic test_final_continuation;
        send_paced(8'hff, 1'b1);
        send_paced(8'h2b, 1'b0);
        send_paced(8'h81, 1'b1);
    endtask

    // 2.(v-80) wrapping below zero gives the 20-digit maximum; then overflow
    task automatic test_wrap_and_overflow;
        send_paced(8'h80, 1'b0);
        send_paced(8'h00, 1'b1);
        send_paced(8'h2b, 1'b0);
        send_paced(8'hc0, 1'b0);
        repeat (8) send_paced(8'h80, 1'b0);
        send_paced(8'h00, 1'b1);
    endtask

    // Append one sub-identifier of 'groups' base-128 groups.
    task automatic add_arc(inout logic [7:0] seq [$], input int groups);
        for (int g = 0; g < groups; g++)
            seq.push_back(g == groups - 1 ? 8'($urandom_range(0, 127))
                                          : 8'($urandom_range(128, 255)));
    endtask

    task automatic send_random_oid;
        logic [7:0] seq [$];
        int         arcs;
        int         groups;
        if ($urandom_range(0, 4) == 0)
            add_arc(seq, $urandom_range(2, 3));   // multi-group first sub-identifier
        else
            seq.push_back(8'($urandom_range(0, 127)));
        arcs = $urandom_range(0, 6);
        for (int a = 0; a < arcs; a++) begin
            case ($urandom_range(0, 19))
                0:       groups = $urandom_range(8, 11);   // overflow territory
                1, 2:    groups = $urandom_range(4, 6);
                default: groups = $urandom_range(1, 3);
            endcase
            add_arc(seq, groups);
        end
        if ($urandom_range(0, 9) == 0)
            seq[seq.size() - 1] = seq[seq.size() - 1] | 8'h80;
        send_sequence(seq);
    endtask

    task automatic send_noise;
        int n;
        n = $urandom_range(1, 6);
        repeat (n) send_paced(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
    endtask

    task automatic test_random_oids(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 6) == 0)
                send_noise();
            else
                send_random_oid();
        end
    endtask

    // sender holds off until the unit has produced everything owed
    task automatic test_drain_pause;
        stop_sending();
        wait_drained();
        repeat (5) @(negedge i_clk);
    endtask

    task automatic test_no_idling;
        quiet = 1'b1;
        test_random_oids(40);
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_stall         = 1'b0;
        i_oid_byte      = '0;
        i_final_byte    = 1'b0;
        arc_value       = '0;
        first_arc_due   = 1'b1;
        arc_lost_bits   = 1'b0;
        arc_in_progress = 1'b0;
        fail_count      = 0;
        cycle_count     = 0;
        bytes_sent      = 0;
        burst_left      = 0;
        quiet           = 1'b0;
        rx_style        = RX_FREE;
        rx_phase_left   = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_first_arc_split();
        test_final_continuation();
        test_wrap_and_overflow();
        test_random_oids(135);
        test_drain_pause();
        test_no_idling();
        test_random_oids(105);

        stop_sending();
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (text_due.size() != 0) begin
            $error("%0d characters never arrived", text_due.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire

/* filelist.f */
rtl/core/boid_pkg.sv
rtl/core/boid_front.sv
rtl/core/boid_fifo.sv
rtl/core/boid_back.sv
rtl/core/ber_oid_to_dotted_decimal_unit.sv
tb/sv/testbench.sv
